// ===== rtl/core/cpsr_pkg.sv =====
// Shared types and constants of the CPU power-state residency counters.
package cpsr_pkg;

    localparam int NUM_FREQ_REGS = 5;
    localparam int LEVEL_W       = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int FREQ_BIN_W    = 3;

    localparam logic [31:0] IDLE_EXIT = 32'hFFFF_FFFF;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET [NUM_FREQ_REGS] = '{
        24'd208000, 24'd432000, 24'd729000, 24'd960000, 24'd1200000
    };

    typedef enum logic [1:0] {
        KIND_IDLE    = 2'd0,
        KIND_FREQ    = 2'd1,
        KIND_RD_IDLE = 2'd2,
        KIND_RD_FREQ = 2'd3
    } kind_t;

    // Per-CPU timing state, kept as one word in the state memory.
    typedef struct packed {
        logic [63:0] idle_stamp;
        logic [31:0] idle_index;
        logic [63:0] freq_stamp;
        logic [31:0] current_freq;
    } cpu_state_t;

    localparam int STATE_W = $bits(cpu_state_t);

    typedef struct packed {
        logic                  hit;
        logic [FREQ_BIN_W-1:0] bin;
    } freq_match_t;

endpackage

// ===== rtl/core/cpsr_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module cpsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cpu_power_state_residency_top.sv =====
// Top level of the CPU power-state residency counters.
//
// Usage: requests arrive on the in_valid/in_ready channel (kind, cpu_number,
// state_value, time_ns, bin_index). Idle and frequency events update the
// per-CPU timing state and may charge elapsed nanoseconds to one residency
// counter; read requests return one counter. Every request gives exactly one
// result on out_valid/out_ready (read_value, read_valid); events return 0/0.
// A request passes stage 1 (per-CPU state read) and stage 2 (residency
// read) before its result enters the output queue.
// in_ready stays low while a request is in stage 1, set by the
// read-modify-write of the per-CPU state memory (read at accept, written
// back in stage 1), then that of the residency memories.
// A two-entry output queue decouples the sides; a stalled receiver holds
// results there, and in_ready drops once two requests are in flight.
// Reset: the frequency levels take their defaults, then a clearing pass
// zeroes all memories, one address a cycle, over CLR_DEPTH addresses
// (max(NUM_CPUS, NUM_CPUS * NUM_IDLE_BINS, NUM_CPUS * NUM_FREQ_BINS), 40 at
// the defaults). in_ready stays low during it; configuration writes on
// cfg_wr_en/cfg_index/cfg_data are taken at any time.
module cpu_power_state_residency_top #(
    parameter int NUM_CPUS      = 8,
    parameter int NUM_FREQ_BINS = 5,
    parameter int NUM_IDLE_BINS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [cpsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpsr_pkg::LEVEL_W-1:0]    cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cpsr_pkg::kind_t                 kind,
    input  logic [2:0]                      cpu_number,
    input  logic [31:0]                     state_value,
    input  logic [63:0]                     time_ns,
    input  logic [2:0]                      bin_index,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     read_value,
    output logic                            read_valid
);

    import cpsr_pkg::*;

    localparam int IR_DEPTH  = NUM_CPUS * NUM_IDLE_BINS;
    localparam int FR_DEPTH  = NUM_CPUS * NUM_FREQ_BINS;
    localparam int CPU_AW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IR_AW     = (IR_DEPTH > 1) ? $clog2(IR_DEPTH) : 1;
    localparam int FR_AW     = (FR_DEPTH > 1) ? $clog2(FR_DEPTH) : 1;
    localparam int CLR_DEPTH0 = (IR_DEPTH > NUM_CPUS) ? IR_DEPTH : NUM_CPUS;
    localparam int CLR_DEPTH  = (FR_DEPTH > CLR_DEPTH0) ? FR_DEPTH : CLR_DEPTH0;
    localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Frequency level registers
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] level_reg [NUM_FREQ_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FREQ_REGS; i++)
            begin
                level_reg[i] <= LEVEL_RESET[i];
            end
        end
        else if (cfg_wr_en && (32'(cfg_index) < NUM_FREQ_REGS))
        begin
            level_reg[cfg_index] <= cfg_data;
        end
    end

    // Lowest-numbered level that matches; bins without a register never match.
    function automatic freq_match_t freq_lookup(input logic [31:0] khz,
                                                input logic [LEVEL_W-1:0] lv [NUM_FREQ_REGS]);
        freq_match_t m;
        m = '0;
        for (int i = NUM_FREQ_REGS - 1; i >= 0; i--)
        begin
            if ((i < NUM_FREQ_BINS) && ({8'd0, lv[i]} == khz))
            begin
                m.hit = 1'b1;
                m.bin = FREQ_BIN_W'(i);
            end
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic             clear_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Accept and pipeline control
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic [1:0] fifo_count_reg;
    logic [2:0] in_flight;
    logic       accept;

    // Hold in_ready low while the previous request reads its state, and
    // whenever two requests already own a queue slot.
    assign in_flight = 3'(fifo_count_reg) + 3'(s1_valid_reg) + 3'(s2_valid_reg);
    assign in_ready  = !clear_reg && !s1_valid_reg && (in_flight < 3'd2);
    assign accept    = in_valid && in_ready;

    // Stage 1 payload: the request, while its CPU state is read.
    kind_t       s1_kind_reg;
    logic        s1_cpu_ok_reg;
    logic [2:0]  s1_cpu_reg;
    logic [31:0] s1_st_reg;
    logic [63:0] s1_time_reg;
    logic [2:0]  s1_bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind;
            s1_cpu_ok_reg <= (7'(cpu_number) < 7'(NUM_CPUS));
            s1_cpu_reg    <= cpu_number;
            s1_st_reg     <= state_value;
            s1_time_reg   <= time_ns;
            s1_bin_reg    <= bin_index;
        end
    end

    // ------------------------------------------------------------------
    // Per-CPU state memory: read at accept, written back in stage 1
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] st_rdata;
    logic [STATE_W-1:0] st_wdata;
    logic [CPU_AW-1:0]  st_waddr;
    logic               st_we;
    cpu_state_t         cur_st;
    cpu_state_t         nxt_st;

    logic [15:0]        in_cpu_wide;
    logic [15:0]        s1_cpu_wide;

    assign in_cpu_wide = 16'(cpu_number);
    assign s1_cpu_wide = 16'(s1_cpu_reg);
    assign cur_st      = cpu_state_t'(st_rdata);

    // Stage 1 event logic
    logic        is_idle_ev;
    logic        is_freq_ev;
    logic        idle_zero;
    logic        freq_zero;
    freq_match_t cur_match;
    logic        charge_idle;
    logic        charge_freq;
    logic [63:0] base_stamp;
    logic [63:0] delta;
    logic        rd_idle_hit;
    logic        rd_freq_hit;

    assign is_idle_ev = s1_valid_reg && s1_cpu_ok_reg && (s1_kind_reg == KIND_IDLE);
    assign is_freq_ev = s1_valid_reg && s1_cpu_ok_reg && (s1_kind_reg == KIND_FREQ);
    assign idle_zero  = (cur_st.idle_stamp == 64'd0);
    assign freq_zero  = (cur_st.freq_stamp == 64'd0);
    assign cur_match  = freq_lookup(cur_st.current_freq, level_reg);

    always_comb
    begin
        nxt_st      = cur_st;
        charge_idle = 1'b0;
        charge_freq = 1'b0;
        if (is_idle_ev)
        begin
            nxt_st.idle_index = s1_st_reg;
            nxt_st.idle_stamp = s1_time_reg;
            if (!idle_zero)
            begin
                if (s1_st_reg != IDLE_EXIT)
                begin
                    // Idle entry: charge the running frequency, if it is known.
                    if (!freq_zero && cur_match.hit)
                    begin
                        charge_freq       = 1'b1;
                        nxt_st.freq_stamp = s1_time_reg;
                    end
                end
                else
                begin
                    charge_idle = (cur_st.idle_index < 32'(NUM_IDLE_BINS));
                    if (!freq_zero)
                    begin
                        nxt_st.freq_stamp = s1_time_reg;
                    end
                end
            end
        end
        else if (is_freq_ev)
        begin
            nxt_st.current_freq = s1_st_reg;
            nxt_st.freq_stamp   = s1_time_reg;
            // Charge the previous frequency only while the CPU is running.
            charge_freq = !freq_zero && (cur_st.idle_index == IDLE_EXIT) && cur_match.hit;
        end
    end

    assign base_stamp = charge_idle ? cur_st.idle_stamp : cur_st.freq_stamp;
    assign delta      = s1_time_reg - base_stamp;

    assign rd_idle_hit = s1_valid_reg && s1_cpu_ok_reg && (s1_kind_reg == KIND_RD_IDLE)
                         && (32'(s1_bin_reg) < NUM_IDLE_BINS);
    assign rd_freq_hit = s1_valid_reg && s1_cpu_ok_reg && (s1_kind_reg == KIND_RD_FREQ)
                         && (32'(s1_bin_reg) < NUM_FREQ_BINS);

    always_comb
    begin
        if (clear_reg)
        begin
            st_we    = (32'(clr_cnt_reg) < NUM_CPUS);
            st_waddr = CPU_AW'(clr_cnt_reg);
            st_wdata = '0;
        end
        else
        begin
            st_we    = is_idle_ev || is_freq_ev;
            st_waddr = s1_cpu_wide[CPU_AW-1:0];
            st_wdata = STATE_W'(nxt_st);
        end
    end

    cpsr_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_CPUS),
        .AW    (CPU_AW)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (in_cpu_wide[CPU_AW-1:0]),
        .rdata (st_rdata)
    );

    // ------------------------------------------------------------------
    // Residency memories: read in stage 1, updated in stage 2
    // ------------------------------------------------------------------
    logic [3:0]  ir_idx;
    logic [2:0]  fr_idx;
    logic [15:0] ir_addr_wide;
    logic [15:0] fr_addr_wide;

    // Reads name the bin directly; charges use the bin left or running.
    assign ir_idx       = (s1_kind_reg == KIND_RD_IDLE) ? {1'b0, s1_bin_reg}
                                                        : cur_st.idle_index[3:0];
    assign fr_idx       = (s1_kind_reg == KIND_RD_FREQ) ? s1_bin_reg : cur_match.bin;
    assign ir_addr_wide = s1_cpu_wide * 16'(NUM_IDLE_BINS) + 16'(ir_idx);
    assign fr_addr_wide = s1_cpu_wide * 16'(NUM_FREQ_BINS) + 16'(fr_idx);

    logic             s2_charge_idle_reg;
    logic             s2_charge_freq_reg;
    logic             s2_rd_hit_reg;
    logic             s2_rd_idle_reg;
    logic [IR_AW-1:0] s2_ir_addr_reg;
    logic [FR_AW-1:0] s2_fr_addr_reg;
    logic [63:0]      s2_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_charge_idle_reg <= charge_idle;
            s2_charge_freq_reg <= charge_freq;
            s2_rd_hit_reg      <= rd_idle_hit || rd_freq_hit;
            s2_rd_idle_reg     <= (s1_kind_reg == KIND_RD_IDLE);
            s2_ir_addr_reg     <= ir_addr_wide[IR_AW-1:0];
            s2_fr_addr_reg     <= fr_addr_wide[FR_AW-1:0];
            s2_delta_reg       <= delta;
        end
    end

    logic [63:0]      ir_rdata;
    logic [63:0]      fr_rdata;
    logic             ir_we;
    logic             fr_we;
    logic [IR_AW-1:0] ir_waddr;
    logic [FR_AW-1:0] fr_waddr;
    logic [63:0]      ir_wdata;
    logic [63:0]      fr_wdata;

    always_comb
    begin
        if (clear_reg)
        begin
            ir_we    = (32'(clr_cnt_reg) < IR_DEPTH);
            fr_we    = (32'(clr_cnt_reg) < FR_DEPTH);
            ir_waddr = IR_AW'(clr_cnt_reg);
            fr_waddr = FR_AW'(clr_cnt_reg);
            ir_wdata = '0;
            fr_wdata = '0;
        end
        else
        begin
            // Counters wrap at 64 bits.
            ir_we    = s2_valid_reg && s2_charge_idle_reg;
            fr_we    = s2_valid_reg && s2_charge_freq_reg;
            ir_waddr = s2_ir_addr_reg;
            fr_waddr = s2_fr_addr_reg;
            ir_wdata = ir_rdata + s2_delta_reg;
            fr_wdata = fr_rdata + s2_delta_reg;
        end
    end

    cpsr_ram #(
        .WIDTH (64),
        .DEPTH (IR_DEPTH),
        .AW    (IR_AW)
    ) u_idle_ram (
        .clk   (clk),
        .we    (ir_we),
        .waddr (ir_waddr),
        .wdata (ir_wdata),
        .re    (s1_valid_reg),
        .raddr (ir_addr_wide[IR_AW-1:0]),
        .rdata (ir_rdata)
    );

    cpsr_ram #(
        .WIDTH (64),
        .DEPTH (FR_DEPTH),
        .AW    (FR_AW)
    ) u_freq_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (s1_valid_reg),
        .raddr (fr_addr_wide[FR_AW-1:0]),
        .rdata (fr_rdata)
    );

    // ------------------------------------------------------------------
    // Two-entry output queue
    // ------------------------------------------------------------------
    logic [63:0] res_value;
    logic [63:0] fifo_value_reg [2];
    logic        fifo_flag_reg  [2];
    logic        fifo_wr_ptr_reg;
    logic        fifo_rd_ptr_reg;
    logic        fifo_pop;

    assign res_value = !s2_rd_hit_reg ? 64'd0 : (s2_rd_idle_reg ? ir_rdata : fr_rdata);
    assign fifo_pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_count_reg  <= 2'd0;
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (s2_valid_reg)
            begin
                fifo_wr_ptr_reg <= !fifo_wr_ptr_reg;
            end
            if (fifo_pop)
            begin
                fifo_rd_ptr_reg <= !fifo_rd_ptr_reg;
            end
            fifo_count_reg <= fifo_count_reg + 2'(s2_valid_reg) - 2'(fifo_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            fifo_value_reg[fifo_wr_ptr_reg] <= res_value;
            fifo_flag_reg[fifo_wr_ptr_reg]  <= s2_rd_hit_reg;
        end
    end

    assign out_valid  = (fifo_count_reg != 2'd0);
    assign read_value = fifo_value_reg[fifo_rd_ptr_reg];
    assign read_valid = fifo_flag_reg[fifo_rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (fifo_count_reg <= 2'd1))
        else $error("result written into a full output queue");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= 3'd2)
        else $error("more than two requests in flight");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> (s2_valid_reg && !s1_valid_reg))
        else $error("stage 1 did not advance or a request overlapped it");

    a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("request in flight during clearing pass");

endmodule

// ===== dv/cpu_power_state_residency_top_test.sv =====
// Self-checking testbench for the CPU idle and frequency residency counters.
module cpu_power_state_residency_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsr_pkg::*;

    localparam int NUM_CPUS      = 8;
    localparam int NUM_FREQ_BINS = 5;
    localparam int NUM_IDLE_BINS = 3;

    // One returned counter, as the result channel carries it.
    typedef struct packed {
        logic [63:0] value;
        logic        valid;
    } counter_read_t;

    // Directed rows either send a request (checked by the predictor, or against
    // the typed-in result), or write a frequency level. For a level write, bin
    // holds the register index and st holds the level in kHz.
    typedef enum logic [1:0] {
        OP_SEND,
        OP_SEND_CHECK,
        OP_WRITE
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        kind_t       kind;
        logic [2:0]  cpu;
        logic [31:0] st;
        logic [63:0] stamp;
        logic [2:0]  bin;
        logic [63:0] exp_value;
        logic        exp_valid;
    } dir_row_t;

    localparam int N_DIRECTED = 28;
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // fresh from reset: existing bins read zero, missing bins miss
        '{OP_SEND_CHECK, KIND_RD_IDLE, 3'd0, 32'd0, 64'd0, 3'd0, 64'd0, 1'b1},
        '{OP_SEND_CHECK, KIND_RD_FREQ, 3'd7, 32'd0, 64'd0, 3'd4, 64'd0, 1'b1},
        '{OP_SEND_CHECK, KIND_RD_IDLE, 3'd3, 32'd0, 64'd0, 3'd3, 64'd0, 1'b0},
        '{OP_SEND_CHECK, KIND_RD_FREQ, 3'd3, 32'd0, 64'd0, 3'd7, 64'd0, 1'b0},
        // events answer 0/0; a zero timestamp leaves the idle mark unset
        '{OP_SEND_CHECK, KIND_IDLE, 3'd1, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0},
        '{OP_SEND_CHECK, KIND_FREQ, 3'd1, 32'd208000, 64'd100, 3'd0, 64'd0, 1'b0},
        // enter state 1, leave it, then change frequency while running
        '{OP_SEND, KIND_IDLE, 3'd1, 32'd1, 64'd250, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd1, 32'hFFFF_FFFF, 64'd400, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_FREQ, 3'd1, 32'd432000, 64'd1000, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_FREQ, 3'd1, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0},
        // idle entry charges the running frequency; exit from a state past
        // the idle bins charges nothing
        '{OP_SEND, KIND_IDLE, 3'd1, 32'd2, 64'd1500, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd1, 32'd7, 64'd1600, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd1, 32'hFFFF_FFFF, 64'd1700, 3'd0, 64'd0, 1'b0},
        // unknown frequency: not charged, and idle entry keeps the old mark
        '{OP_SEND, KIND_FREQ, 3'd1, 32'd12345, 64'd2000, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd1, 32'd0, 64'd2100, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_IDLE, 3'd1, 32'd0, 64'd0, 3'd1, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_FREQ, 3'd1, 32'd0, 64'd0, 3'd1, 64'd0, 1'b0},
        // duplicate level, zero level, and a write past the last register
        '{OP_WRITE, KIND_IDLE, 3'd0, 32'd432000, 64'd0, 3'd2, 64'd0, 1'b0},
        '{OP_WRITE, KIND_IDLE, 3'd0, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0},
        '{OP_WRITE, KIND_IDLE, 3'd0, 32'h00FF_FFFF, 64'd0, 3'd5, 64'd0, 1'b0},
        // lowest matching bin wins; all-ones timestamp and wrap-around deltas
        '{OP_SEND, KIND_FREQ, 3'd2, 32'd432000, 64'd5, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd2, 32'd0, 64'd10, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_IDLE, 3'd2, 32'hFFFF_FFFF, 64'd20, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_FREQ, 3'd2, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_FREQ, 3'd2, 32'hFFFF_FFFF, 64'd3, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_FREQ, 3'd2, 32'd0, 64'd0, 3'd1, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_FREQ, 3'd2, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0},
        '{OP_SEND, KIND_RD_IDLE, 3'd2, 32'd0, 64'd0, 3'd0, 64'd0, 1'b0}
    };

    localparam int ITEMS_PER_PHASE = 625;

    // DUT ports
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    kind_t                kind;
    logic [2:0]           cpu_number;
    logic [31:0]          state_value;
    logic [63:0]          time_ns;
    logic [2:0]           bin_index;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [63:0]          read_value;
    logic                 read_valid;

    // Predictor state: levels, per-CPU marks and the residency counters.
    logic [LEVEL_W-1:0] level_khz [NUM_FREQ_REGS];
    logic [63:0]        idle_mark  [NUM_CPUS];
    logic [31:0]        idle_state [NUM_CPUS];
    logic [63:0]        freq_mark  [NUM_CPUS];
    logic [31:0]        run_khz    [NUM_CPUS];
    logic [63:0]        idle_ns    [NUM_CPUS][NUM_IDLE_BINS];
    logic [63:0]        freq_ns    [NUM_CPUS][NUM_FREQ_BINS];

    // Counters still owed by the block, oldest first.
    counter_read_t pending_reads [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    int          fail_count;
    int          n_requests;
    int          n_results;
    int          n_hits;
    logic [63:0] now_ns;

    cpu_power_state_residency_top #(
        .NUM_CPUS      (NUM_CPUS),
        .NUM_FREQ_BINS (NUM_FREQ_BINS),
        .NUM_IDLE_BINS (NUM_IDLE_BINS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .cpu_number  (cpu_number),
        .state_value (state_value),
        .time_ns     (time_ns),
        .bin_index   (bin_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .read_valid  (read_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run (~0.1 ms at the worst stalls).
    initial
    begin
        #10_000_000;
        $display("[cpu_power_state_residency_top] ERROR");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // Bin of a frequency: lowest level that matches, or NUM_FREQ_BINS for none.
    // Bins without a level register never match.
    function automatic int khz_bin(input logic [31:0] khz);
        for (int i = 0; i < NUM_FREQ_BINS && i < NUM_FREQ_REGS; i++)
            if ({8'd0, level_khz[i]} == khz)
                return i;
        return NUM_FREQ_BINS;
    endfunction

    // Advance the predictor by one accepted request and return its result.
    function automatic counter_read_t predict_step(input kind_t k, input logic [2:0] cpu,
                                                   input logic [31:0] st,
                                                   input logic [63:0] stamp,
                                                   input logic [2:0] bin);
        counter_read_t r;
        logic [31:0]   left_idle;
        logic [31:0]   prev_khz;
        logic [63:0]   since_idle;
        logic [63:0]   since_freq;
        int            b;
        r = '0;
        case (k)
            KIND_IDLE:
            begin
                left_idle = idle_state[cpu];
                idle_state[cpu] = st;
                if (idle_mark[cpu] == '0)
                begin
                    // first mark only starts timing
                    idle_mark[cpu] = stamp;
                end
                else
                begin
                    since_idle = stamp - idle_mark[cpu];
                    idle_mark[cpu] = stamp;
                    if (st != IDLE_EXIT)
                    begin
                        // entry: charge the running frequency, if marked and known
                        b = khz_bin(run_khz[cpu]);
                        if (freq_mark[cpu] != '0 && b < NUM_FREQ_BINS)
                        begin
                            freq_ns[cpu][3'(b)] += stamp - freq_mark[cpu];
                            freq_mark[cpu] = stamp;
                        end
                    end
                    else
                    begin
                        if (left_idle < NUM_IDLE_BINS)
                            idle_ns[cpu][2'(left_idle)] += since_idle;
                        if (freq_mark[cpu] != '0)
                            freq_mark[cpu] = stamp;
                    end
                end
            end
            KIND_FREQ:
            begin
                prev_khz = run_khz[cpu];
                run_khz[cpu] = st;
                if (freq_mark[cpu] == '0)
                begin
                    freq_mark[cpu] = stamp;
                end
                else
                begin
                    since_freq = stamp - freq_mark[cpu];
                    freq_mark[cpu] = stamp;
                    // only a running CPU charges the frequency it leaves
                    b = khz_bin(prev_khz);
                    if (idle_state[cpu] == IDLE_EXIT && b < NUM_FREQ_BINS)
                        freq_ns[cpu][3'(b)] += since_freq;
                end
            end
            KIND_RD_IDLE:
            begin
                if (bin < NUM_IDLE_BINS)
                begin
                    r.value = idle_ns[cpu][2'(bin)];
                    r.valid = 1'b1;
                end
            end
            default:
            begin
                if (bin < NUM_FREQ_BINS)
                begin
                    r.value = freq_ns[cpu][bin];
                    r.valid = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request, hold it until accepted, then predict its result.
    task automatic send_request(input kind_t k, input logic [2:0] cpu,
                                input logic [31:0] st, input logic [63:0] stamp,
                                input logic [2:0] bin, output counter_read_t predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        cpu_number  <= cpu;
        state_value <= st;
        time_ns     <= stamp;
        bin_index   <= bin;
        // in_ready read right after the edge is its value at that edge
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_step(k, cpu, st, stamp, bin);
        n_requests++;
    endtask

    // Write one level register once the block has returned every result.
    // Hold the enable high when another write follows in the next cycle.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] khz,
                             input bit hold);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= khz;
        @(posedge clk);
        if (!hold)
            cfg_wr_en <= 1'b0;
        if (idx < NUM_FREQ_REGS)
            level_khz[idx] = khz;
    endtask

    // Mostly well-formed traffic: timestamps advance on a shared clock, idle
    // states stay in range, frequencies come from the programmed levels. A
    // small share is noise: arbitrary stamps, zero stamps, wild values.
    task automatic send_random_item();
        kind_t         k;
        logic [31:0]   st;
        logic [63:0]   stamp;
        int            pick;
        counter_read_t predicted;
        pick = $urandom_range(99);
        if (pick < 35)
            k = KIND_IDLE;
        else if (pick < 60)
            k = KIND_FREQ;
        else if (pick < 80)
            k = KIND_RD_IDLE;
        else
            k = KIND_RD_FREQ;
        now_ns += 64'($urandom_range(1, 5000));
        pick = $urandom_range(99);
        if (pick < 2)
            stamp = {$urandom, $urandom};
        else if (pick < 3)
            stamp = '0;
        else
            stamp = now_ns;
        pick = $urandom_range(99);
        if (k == KIND_IDLE)
        begin
            if (pick < 40)
                st = IDLE_EXIT;
            else if (pick < 85)
                st = $urandom_range(NUM_IDLE_BINS - 1);
            else if (pick < 95)
                st = $urandom_range(15);
            else
                st = $urandom;
        end
        else if (pick < 80)
            st = 32'(level_khz[3'($urandom_range(NUM_FREQ_REGS - 1))]);
        else
            st = $urandom;
        send_request(k, 3'($urandom), st, stamp, 3'($urandom), predicted);
        pending_reads.push_back(predicted);
    endtask

    // Result side: stall at random and compare every returned counter with
    // the oldest prediction.
    always @(posedge clk)
    begin : result_check
        counter_read_t want;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (read_valid)
                n_hits++;
            if (pending_reads.size() == 0)
            begin
                note_failure($sformatf("unexpected result: value %h valid %b",
                                       read_value, read_valid));
            end
            else
            begin
                want = pending_reads.pop_front();
                if (read_value !== want.value || read_valid !== want.valid)
                    note_failure($sformatf(
                        "result %0d mismatch: expected value %h valid %b, got value %h valid %b",
                        n_results, want.value, want.valid, read_value, read_valid));
            end
        end
    end

    initial
    begin : stimulus
        counter_read_t      predicted;
        logic [LEVEL_W-1:0] levels [NUM_FREQ_REGS];
        int                 guard;

        // Drive every input to a known value and hold reset.
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        kind        <= KIND_IDLE;
        cpu_number  <= '0;
        state_value <= '0;
        time_ns     <= '0;
        bin_index   <= '0;
        send_idle_pct = 29;
        recv_idle_pct = 73;
        fail_count    = 0;
        n_requests    = 0;
        n_results     = 0;
        n_hits        = 0;
        now_ns        = 64'd1000;

        // Predictor reset: default levels, all marks and counters zero.
        level_khz = LEVEL_RESET;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            idle_mark[c]  = '0;
            idle_state[c] = '0;
            freq_mark[c]  = '0;
            run_khz[c]    = '0;
            for (int i = 0; i < NUM_IDLE_BINS; i++)
                idle_ns[c][i] = '0;
            for (int i = 0; i < NUM_FREQ_BINS; i++)
                freq_ns[c][i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // The clearing pass after reset keeps in_ready low; the first
        // handshake simply waits it out.

        // Directed table: walk it in order with the first idle profile.
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (DIRECTED_ROWS[r].op == OP_WRITE)
            begin
                write_cfg(DIRECTED_ROWS[r].bin, DIRECTED_ROWS[r].st[LEVEL_W-1:0],
                          r != N_DIRECTED - 1 && DIRECTED_ROWS[r + 1].op == OP_WRITE);
            end
            else
            begin
                send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].cpu,
                             DIRECTED_ROWS[r].st, DIRECTED_ROWS[r].stamp,
                             DIRECTED_ROWS[r].bin, predicted);
                // rows with a result readable at a glance carry it typed in
                if (DIRECTED_ROWS[r].op == OP_SEND_CHECK)
                    pending_reads.push_back(counter_read_t'{
                        value: DIRECTED_ROWS[r].exp_value,
                        valid: DIRECTED_ROWS[r].exp_valid});
                else
                    pending_reads.push_back(predicted);
            end
        end

        // Random part in three phases, each with its own level setting and
        // idle profile: slow receiver, then slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    levels = '{24'd0, 24'hFF_FFFF, 24'd729000, 24'd960000, 24'd1200000};
                    send_idle_pct = 29;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    for (int i = 0; i < NUM_FREQ_REGS; i++)
                        levels[i] = LEVEL_W'($urandom);
                    // force a duplicate so the lowest bin has to win
                    levels[3] = levels[1];
                    send_idle_pct = 73;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    levels = LEVEL_RESET;
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Program all five levels back to back, then one stray index.
            for (int i = 0; i < NUM_FREQ_REGS; i++)
                write_cfg(CFG_IDX_W'(i), levels[i], 1'b1);
            write_cfg(CFG_IDX_W'(5 + phase), LEVEL_W'($urandom), 1'b0);
            repeat (ITEMS_PER_PHASE)
                send_random_item();
        end

        // Drop valid, drain, then leave a few cycles for stray results.
        in_valid <= 1'b0;
        guard = 0;
        while (pending_reads.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_reads.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_reads.size()));

        $display("Run covered %0d requests and %0d results, %0d of them bin reads that hit,",
                 n_requests, n_results, n_hits);
        $display("under five level settings and three handshake idle profiles; %0d failures.",
                 fail_count);
        if (fail_count == 0)
            $display("[cpu_power_state_residency_top] OK");
        else
            $display("[cpu_power_state_residency_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cpsr_pkg.sv
rtl/core/cpsr_ram.sv
rtl/core/cpu_power_state_residency_top.sv
dv/cpu_power_state_residency_top_test.sv
